FILE: rtl/core/psd_pkg.sv
// Shared constants for the point-to-segment squared distance pipeline.
package psd_pkg;

  // Projection parameter: unsigned, FRAC_H fraction bits, h = 1 is 2**FRAC_H.
  localparam int FRAC_H    = 24;
  localparam int H_W       = FRAC_H + 1;
  localparam int DIV_STEPS = FRAC_H;

  // Residual component, rounded to 2**-16 and capped at 2**26.
  localparam int RND_SHIFT = 16;
  localparam int RND_HALF  = 1 << (RND_SHIFT - 1);
  localparam int CAP_W     = 27;
  localparam longint unsigned RESID_CAP = 64'd1 << (CAP_W - 1);

  // Squares, their sum and the final result.
  localparam int SQ_W         = 2 * CAP_W;
  localparam int SUM_W        = SQ_W + 1;
  localparam int SUM_SH_W     = SUM_W - RND_SHIFT;
  localparam int OUT_W        = 34;
  localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;

  // Pipeline: diffs, products, sums, divider steps, then five residual stages.
  localparam int ST_DIV0    = 2;
  localparam int ST_M1      = ST_DIV0 + DIV_STEPS + 1;
  localparam int PIPE_DEPTH = ST_M1 + 5;

  // Configuration register map.
  localparam int CFG_ADDR_W = 8;
  localparam logic [CFG_ADDR_W-1:0] REG_START_X = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_START_Y = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_END_X   = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_END_Y   = 8'd3;

endpackage

FILE: rtl/core/point_segment_sq_distance.sv
// Squared distance from a streamed query point to a configured 2-D segment.
//
// Usage:
//   cfg channel (cfg_valid_i/cfg_ready_o, cfg_addr_i, cfg_data_i) writes the
//   segment end points: index 0 start_x, 1 start_y, 2 end_x, 3 end_y, signed
//   Q7.8 at the default width. Other indexes are ignored. cfg_ready_o is
//   always high. Write only while no word is in flight.
//   s_axis carries query points, m_axis returns dist_squared (unsigned Q18.16,
//   saturated to 2**34-1), one result word per query word, in order.
// Timing:
//   32 register stages: differences, products, dot/length sums, 24 restoring
//   divider steps (one quotient bit per stage), then residual product,
//   residual difference, round/cap, squares and the final sum.
//   One word per cycle sustained while m_axis_tready stays high.
// Reset and stall:
//   Reset clears all stage valids and the segment registers to zero.
//   Each stage holds while the one after it is full and stalled; empty
//   stages keep filling, so input is taken until all 32 stages hold words.
module point_segment_sq_distance #(
  parameter int COORD_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [psd_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [COORD_BITS-1:0]             cfg_data_i,

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // query_x, query_y (from bit 0 up), zero padded to bytes
  input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // dist_squared (from bit 0 up), zero padded to bytes
  output logic [psd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int W     = COORD_BITS;
  localparam int DW    = W + 1;          // coordinate differences
  localparam int PW    = 2 * W + 2;      // difference products
  localparam int DOTW  = 2 * W + 3;      // signed dot product
  localparam int RW    = 2 * W + 2;      // squared length, divider remainder
  localparam int TW    = W + 27;         // residual before rounding, 2**-32 units
  localparam int CFW   = TW - psd_pkg::RND_SHIFT;
  localparam int NS    = psd_pkg::PIPE_DEPTH;
  localparam int NDIV  = psd_pkg::DIV_STEPS;
  localparam int HW    = psd_pkg::H_W;
  localparam int CAPW  = psd_pkg::CAP_W;
  localparam int ST_M1 = psd_pkg::ST_M1;

  // ---------------------------------------------------------------- config
  logic signed [W-1:0] start_x_q, start_y_q, end_x_q, end_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        psd_pkg::REG_START_X: start_x_q <= cfg_data_i;
        psd_pkg::REG_START_Y: start_y_q <= cfg_data_i;
        psd_pkg::REG_END_X:   end_x_q   <= cfg_data_i;
        psd_pkg::REG_END_Y:   end_y_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------- stage control
  logic [NS-1:0] vld_q, vld_d;
  logic [NS-1:0] stage_en;

  // A stage loads when it is empty or its successor loads too.
  always_comb begin
    stage_en[NS-1] = !vld_q[NS-1] || m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      stage_en[k] = !vld_q[k] || stage_en[k+1];
    end
    for (int k = 0; k < NS; k++) begin
      if (!stage_en[k]) begin
        vld_d[k] = vld_q[k];
      end else if (k == 0) begin
        vld_d[k] = s_axis_tvalid;
      end else begin
        vld_d[k] = vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = stage_en[0];

  // ------------------------------------------------------ stage 0: diffs
  logic signed [W-1:0]  query_x, query_y;
  logic signed [DW-1:0] px_d, py_d, dx_d, dy_d;
  logic signed [DW-1:0] px_q, py_q, dx_q, dy_q;

  assign query_x = s_axis_tdata[W-1:0];
  assign query_y = s_axis_tdata[2*W-1:W];
  assign px_d = DW'(query_x) - DW'(start_x_q);
  assign py_d = DW'(query_y) - DW'(start_y_q);
  assign dx_d = DW'(end_x_q) - DW'(start_x_q);
  assign dy_d = DW'(end_y_q) - DW'(start_y_q);

  always_ff @(posedge clk_i) begin
    if (stage_en[0]) begin
      px_q <= px_d;
      py_q <= py_d;
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  // --------------------------------------------------- stage 1: products
  logic signed [PW-1:0] dxp_d, dyp_d, dxx_d, dyy_d;
  logic signed [PW-1:0] dxp_q, dyp_q, dxx_q, dyy_q;
  logic signed [DW-1:0] px1_q, py1_q, dx1_q, dy1_q;

  assign dxp_d = dx_q * px_q;
  assign dyp_d = dy_q * py_q;
  assign dxx_d = dx_q * dx_q;
  assign dyy_d = dy_q * dy_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      dxp_q <= dxp_d;
      dyp_q <= dyp_d;
      dxx_q <= dxx_d;
      dyy_q <= dyy_d;
      px1_q <= px_q;
      py1_q <= py_q;
      dx1_q <= dx_q;
      dy1_q <= dy_q;
    end
  end

  // ------------------------- stage 2: sums and range check, divider steps
  // Index 0 of the divider arrays is stage 2; index j is divider step j.
  logic signed [DOTW-1:0] dot_d;
  logic [RW-1:0]          bb_d;
  logic                   h_zero, h_full;

  logic [RW-1:0]          dv_rem_d [0:NDIV];
  logic [RW-1:0]          dv_rem_q [0:NDIV];
  logic [NDIV-1:0]        dv_quo_d [0:NDIV];
  logic [NDIV-1:0]        dv_quo_q [0:NDIV];
  logic [RW-1:0]          dv_bb_d  [0:NDIV];
  logic [RW-1:0]          dv_bb_q  [0:NDIV];
  logic                   dv_full_d [0:NDIV];
  logic                   dv_full_q [0:NDIV];
  logic signed [DW-1:0]   dv_px_d [0:NDIV];
  logic signed [DW-1:0]   dv_px_q [0:NDIV];
  logic signed [DW-1:0]   dv_py_d [0:NDIV];
  logic signed [DW-1:0]   dv_py_q [0:NDIV];
  logic signed [DW-1:0]   dv_dx_d [0:NDIV];
  logic signed [DW-1:0]   dv_dx_q [0:NDIV];
  logic signed [DW-1:0]   dv_dy_d [0:NDIV];
  logic signed [DW-1:0]   dv_dy_q [0:NDIV];

  assign dot_d  = DOTW'(dxp_q) + DOTW'(dyp_q);
  assign bb_d   = RW'(dxx_q[2*W:0]) + RW'(dyy_q[2*W:0]);
  // Non-positive projection (also the degenerate segment) gives h = 0.
  assign h_zero = dot_d[DOTW-1] || (dot_d == '0);
  assign h_full = !h_zero && (RW'(dot_d) >= bb_d);

  always_comb begin
    logic [RW:0] sh;
    logic [RW:0] diff;
    logic        ge;
    dv_rem_d[0]  = (h_zero || h_full) ? '0 : RW'(dot_d);
    dv_quo_d[0]  = '0;
    dv_bb_d[0]   = bb_d;
    dv_full_d[0] = h_full;
    dv_px_d[0]   = px1_q;
    dv_py_d[0]   = py1_q;
    dv_dx_d[0]   = dx1_q;
    dv_dy_d[0]   = dy1_q;
    for (int j = 1; j <= NDIV; j++) begin
      // One restoring step: remainder stays below the divisor.
      sh   = {dv_rem_q[j-1], 1'b0};
      diff = sh - {1'b0, dv_bb_q[j-1]};
      ge   = (sh >= {1'b0, dv_bb_q[j-1]});
      dv_rem_d[j]  = ge ? diff[RW-1:0] : sh[RW-1:0];
      dv_quo_d[j]  = {dv_quo_q[j-1][NDIV-2:0], ge};
      dv_bb_d[j]   = dv_bb_q[j-1];
      dv_full_d[j] = dv_full_q[j-1];
      dv_px_d[j]   = dv_px_q[j-1];
      dv_py_d[j]   = dv_py_q[j-1];
      dv_dx_d[j]   = dv_dx_q[j-1];
      dv_dy_d[j]   = dv_dy_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= NDIV; j++) begin
      if (stage_en[psd_pkg::ST_DIV0 + j]) begin
        dv_rem_q[j]  <= dv_rem_d[j];
        dv_quo_q[j]  <= dv_quo_d[j];
        dv_bb_q[j]   <= dv_bb_d[j];
        dv_full_q[j] <= dv_full_d[j];
        dv_px_q[j]   <= dv_px_d[j];
        dv_py_q[j]   <= dv_py_d[j];
        dv_dx_q[j]   <= dv_dx_d[j];
        dv_dy_q[j]   <= dv_dy_d[j];
      end
    end
  end

  // ------------------------------------------------ M1: d * h products
  // Clamped cases left the quotient at zero; a degenerate segment fills it
  // with ones, but there d is zero and so is d * h.
  logic signed [HW:0]   h_s;
  logic signed [TW-1:0] hx_d, hy_d, hx_q, hy_q;
  logic signed [DW-1:0] px2_q, py2_q;

  assign h_s  = $signed({1'b0, dv_full_q[NDIV], dv_quo_q[NDIV]});
  assign hx_d = dv_dx_q[NDIV] * h_s;
  assign hy_d = dv_dy_q[NDIV] * h_s;

  always_ff @(posedge clk_i) begin
    if (stage_en[ST_M1]) begin
      hx_q  <= hx_d;
      hy_q  <= hy_d;
      px2_q <= dv_px_q[NDIV];
      py2_q <= dv_py_q[NDIV];
    end
  end

  // ------------------------------------------- M2: residual p*2^24 - d*h
  logic signed [DW+psd_pkg::FRAC_H-1:0] pxs, pys;
  logic signed [TW-1:0] tx_d, ty_d, tx_q, ty_q;

  assign pxs  = $signed({px2_q, {psd_pkg::FRAC_H{1'b0}}});
  assign pys  = $signed({py2_q, {psd_pkg::FRAC_H{1'b0}}});
  assign tx_d = TW'(pxs) - hx_q;
  assign ty_d = TW'(pys) - hy_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[ST_M1+1]) begin
      tx_q <= tx_d;
      ty_q <= ty_d;
    end
  end

  // ------------------------------------------ M3: magnitude, round, cap
  function automatic logic [CAPW-1:0] resid_round(input logic [TW-1:0] t);
    logic          neg;
    logic [TW-1:0] mag1;
    logic [TW-1:0] rsum;
    logic [CFW-1:0] c_full;
    neg  = t[TW-1];
    // |t| + half: for negative t, ~t + 1 + half in one add.
    mag1 = neg ? ~t : t;
    rsum = mag1 + (neg ? TW'(psd_pkg::RND_HALF + 1) : TW'(psd_pkg::RND_HALF));
    c_full = rsum[TW-1:psd_pkg::RND_SHIFT];
    if (64'(c_full) > psd_pkg::RESID_CAP) begin
      return CAPW'(psd_pkg::RESID_CAP);
    end
    return CAPW'(c_full);
  endfunction

  logic [CAPW-1:0] cx_q, cy_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[ST_M1+2]) begin
      cx_q <= resid_round(tx_q);
      cy_q <= resid_round(ty_q);
    end
  end

  // -------------------------------------------------------- M4: squares
  logic [psd_pkg::SQ_W-1:0] sqx_q, sqy_q;

  always_ff @(posedge clk_i) begin
    if (stage_en[ST_M1+3]) begin
      sqx_q <= cx_q * cx_q;
      sqy_q <= cy_q * cy_q;
    end
  end

  // ---------------------------------------- M5: sum, round, saturate, out
  logic [psd_pkg::SUM_W-1:0]    sum_d;
  logic [psd_pkg::SUM_SH_W-1:0] sum_sh;
  logic [psd_pkg::OUT_W-1:0]    dist_d, dist_q;

  assign sum_d  = psd_pkg::SUM_W'(sqx_q) + psd_pkg::SUM_W'(sqy_q)
                + psd_pkg::SUM_W'(psd_pkg::RND_HALF);
  assign sum_sh = sum_d[psd_pkg::SUM_W-1:psd_pkg::RND_SHIFT];
  assign dist_d = (|sum_sh[psd_pkg::SUM_SH_W-1:psd_pkg::OUT_W]) ? '1
                : sum_sh[psd_pkg::OUT_W-1:0];

  always_ff @(posedge clk_i) begin
    if (stage_en[NS-1]) begin
      dist_q <= dist_d;
    end
  end

  assign m_axis_tvalid = vld_q[NS-1];
  assign m_axis_tdata  = psd_pkg::OUT_TDATA_W'(dist_q);

endmodule

FILE: rtl/core/psd_checker.sv
// Port-level checker for point_segment_sq_distance, bound to the top level.
module psd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [psd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  localparam int CntW = $clog2(psd_pkg::PIPE_DEPTH + 1) + 1;

  logic [CntW-1:0] inflight_q;
  logic            in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // words accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CntW'(in_acc) - CntW'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != '0)
    else $error("output word without a matching input word");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CntW'(psd_pkg::PIPE_DEPTH))
    else $error("more words in flight than pipeline stages");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[psd_pkg::OUT_TDATA_W-1:psd_pkg::OUT_W] == '0)
    else $error("output padding bits not zero");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write not taken");

endmodule

bind point_segment_sq_distance psd_checker u_psd_checker (.*);

FILE: bench/point_segment_sq_distance_tb.sv
// Self-checking bench for the point-to-segment squared distance stream block.
`timescale 1ns / 1ps

module point_segment_sq_distance_tb;

  localparam int COORD_W     = 16;
  localparam int DIST_W      = 34;
  localparam int HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT = 4000;
  localparam int N_PHASES    = 9;
  localparam int PHASE_ITEMS = 150;

  // Fixed-point constants of the distance arithmetic.
  localparam int     H_FRAC   = 24;
  localparam longint H_ONE    = 64'sd1 << H_FRAC;
  localparam int     Q16      = 16;
  localparam longint HALF_LSB = 64'sd1 << (Q16 - 1);
  localparam longint C_CAP    = 64'sd1 << 26;
  localparam longint DIST_SAT = (64'sd1 << DIST_W) - 1;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t C_MIN = 16'sh8000;
  localparam coord_t C_MAX = 16'sh7fff;

  typedef enum int {SEG_RANDOM, SEG_DEGENERATE, SEG_CORNERS, SEG_SHORT, SEG_AXIS} seg_shape_e;
  typedef enum int {Q_ANY, Q_NEAR_START, Q_ALONG, Q_CORNER} query_shape_e;

  typedef struct packed {
    coord_t            ax, ay, bx, by;
    coord_t            qx, qy;
    logic              typed;
    logic [DIST_W-1:0] exp_dist;
  } dir_row_t;

  localparam int N_DIR = 20;
  localparam dir_row_t DIR_ROWS [N_DIR] = '{
    // reset segment: A = B = origin
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, 34'd0},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 1'b1, 34'd1},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, C_MIN, C_MIN, 1'b1, 34'd2147483648},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, C_MAX, C_MAX, 1'b1, 34'd2147352578},
    '{16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1, C_MIN, 1'b0, 34'd0},
    // unit segment along x: beyond B, before A, mid projection, on B
    '{16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd512, 16'sd0, 1'b1, 34'd65536},
    '{16'sd0, 16'sd0, 16'sd256, 16'sd0, -16'sd256, 16'sd0, 1'b1, 34'd65536},
    '{16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd128, 16'sd256, 1'b1, 34'd65536},
    '{16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd256, 16'sd0, 1'b1, 34'd0},
    '{16'sd0, 16'sd0, 16'sd256, 16'sd0, 16'sd77, -16'sd300, 1'b0, 34'd0},
    // degenerate away from the origin
    '{16'sd1000, -16'sd1000, 16'sd1000, -16'sd1000, 16'sd1000, -16'sd1000, 1'b1, 34'd0},
    '{16'sd1000, -16'sd1000, 16'sd1000, -16'sd1000, -16'sd3, 16'sd5, 1'b0, 34'd0},
    // full-range diagonal
    '{C_MIN, C_MIN, C_MAX, C_MAX, C_MIN, C_MIN, 1'b1, 34'd0},
    '{C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MAX, 1'b1, 34'd0},
    '{C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, 1'b0, 34'd0},
    // largest distance the coordinates allow
    '{C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, 1'b1, 34'd8589672450},
    '{C_MAX, C_MIN, C_MIN, C_MAX, 16'sd0, 16'sd0, 1'b0, 34'd0},
    '{C_MAX, C_MIN, C_MIN, C_MAX, -16'sd1, -16'sd1, 1'b0, 34'd0},
    '{-16'sd5, 16'sd7, 16'sd300, -16'sd129, 16'sd100, -16'sd60, 1'b0, 34'd0},
    '{-16'sd5, 16'sd7, 16'sd300, -16'sd129, 16'sd1234, -16'sd4321, 1'b0, 34'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [psd_pkg::CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [COORD_W-1:0]               cfg_data = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [2*COORD_W-1:0]             s_axis_tdata = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [psd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;

  // Segment registers as the block should hold them.
  coord_t seg_ax = '0, seg_ay = '0, seg_bx = '0, seg_by = '0;

  logic [DIST_W-1:0] expected_dist [$];
  int  n_sent = 0, n_results = 0, n_errors = 0, n_cfg_writes = 0, n_segments = 1;
  int  quiet_cycles = 0;
  bit  send_idle = 1'b1, recv_idle = 1'b1, hold_req = 1'b0;

  point_segment_sq_distance #(.COORD_BITS(COORD_W)) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Magnitude of one residual component, rounded to 2^-16 and capped.
  function automatic longint rounded_residual(input longint p, input longint d, input longint h);
    longint t;
    t = p * H_ONE - d * h;
    if (t < 0) t = -t;
    t = (t + HALF_LSB) >>> Q16;
    return (t > C_CAP) ? C_CAP : t;
  endfunction

  function automatic logic [DIST_W-1:0] sq_dist_to_segment(input coord_t qx, input coord_t qy);
    longint px, py, dx, dy, len_sq, dot, h, cx, cy, sum;
    px = longint'(qx) - longint'(seg_ax);
    py = longint'(qy) - longint'(seg_ay);
    dx = longint'(seg_bx) - longint'(seg_ax);
    dy = longint'(seg_by) - longint'(seg_ay);
    len_sq = dx * dx + dy * dy;
    dot = dx * px + dy * py;
    h = 0;
    // clamp to [0,1]; a zero-length segment keeps h at 0
    if (len_sq != 0 && dot > 0)
      h = (dot >= len_sq) ? H_ONE : (dot <<< H_FRAC) / len_sq;
    cx = rounded_residual(px, dx, h);
    cy = rounded_residual(py, dy, h);
    sum = (cx * cx + cy * cy + HALF_LSB) >>> Q16;
    if (sum > DIST_SAT) sum = DIST_SAT;
    return sum[DIST_W-1:0];
  endfunction

  // Stop offering words, then wait until every sent word has come back.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (n_results < n_sent) @(posedge clk_i);
  endtask

  // Four segment registers, then one write to an unmapped index that must be dropped.
  task automatic set_segment(input coord_t ax, input coord_t ay, input coord_t bx,
                             input coord_t by);
    logic [psd_pkg::CFG_ADDR_W-1:0] addr [5];
    logic [COORD_W-1:0]             data [5];
    addr = '{psd_pkg::REG_START_X, psd_pkg::REG_START_Y,
             psd_pkg::REG_END_X, psd_pkg::REG_END_Y,
             psd_pkg::CFG_ADDR_W'($urandom_range(4, (1 << psd_pkg::CFG_ADDR_W) - 1))};
    data = '{ax, ay, bx, by, COORD_W'($urandom)};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_addr  <= addr[i];
      cfg_data  <= data[i];
      do @(posedge clk_i); while (!cfg_ready);
      case (addr[i])
        psd_pkg::REG_START_X: seg_ax = data[i];
        psd_pkg::REG_START_Y: seg_ay = data[i];
        psd_pkg::REG_END_X:   seg_bx = data[i];
        psd_pkg::REG_END_Y:   seg_by = data[i];
        default: ;
      endcase
      n_cfg_writes++;
    end
    cfg_valid <= 1'b0;
    n_segments++;
  endtask

  task automatic send_point(input coord_t qx, input coord_t qy, input logic typed,
                            input logic [DIST_W-1:0] typed_dist);
    int gap;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {qy, qx};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_dist.push_back(typed ? typed_dist : sq_dist_to_segment(qx, qy));
    n_sent++;
  endtask

  function automatic coord_t pick_corner();
    case ($urandom_range(0, 4))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      3: return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic coord_t near_line(input coord_t a, input coord_t b, input int k);
    int off;
    off = int'($urandom_range(0, 63)) - 32;
    return coord_t'(int'(a) + ((int'(b) - int'(a)) * k) / 16 + off);
  endfunction

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (recv_idle) begin
        stall = $urandom_range(0, 8);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Result checker and activity tracking.
  always @(posedge clk_i) begin
    logic [DIST_W-1:0] want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (expected_dist.size() == 0) begin
          if (n_errors < 10)
            $display("ERROR: dist word %0h with nothing expected", m_axis_tdata[DIST_W-1:0]);
          n_errors++;
        end else begin
          want = expected_dist.pop_front();
          if (m_axis_tdata[DIST_W-1:0] !== want) begin
            if (n_errors < 10)
              $display("ERROR: word %0d dist_squared expected %0d got %0d",
                       n_results - 1, want, m_axis_tdata[DIST_W-1:0]);
            n_errors++;
          end
        end
      end
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    seg_shape_e   shape;
    query_shape_e qshape;
    coord_t       ax, ay, bx, by, qx, qy;
    int           k;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; the first ones run on the reset segment.
    foreach (DIR_ROWS[r]) begin
      if (DIR_ROWS[r].ax != seg_ax || DIR_ROWS[r].ay != seg_ay ||
          DIR_ROWS[r].bx != seg_bx || DIR_ROWS[r].by != seg_by) begin
        wait_drained();
        set_segment(DIR_ROWS[r].ax, DIR_ROWS[r].ay, DIR_ROWS[r].bx, DIR_ROWS[r].by);
      end
      send_point(DIR_ROWS[r].qx, DIR_ROWS[r].qy, DIR_ROWS[r].typed, DIR_ROWS[r].exp_dist);
    end

    for (int phase = 0; phase < N_PHASES; phase++) begin
      wait_drained();
      ax = coord_t'($urandom);
      ay = coord_t'($urandom);
      bx = coord_t'($urandom);
      by = coord_t'($urandom);
      shape = seg_shape_e'(phase % 5);
      case (shape)
        SEG_DEGENERATE: begin
          bx = ax;
          by = ay;
        end
        SEG_CORNERS: begin
          ax = $urandom_range(0, 1) ? C_MAX : C_MIN;
          ay = $urandom_range(0, 1) ? C_MAX : C_MIN;
          bx = $urandom_range(0, 1) ? C_MAX : C_MIN;
          by = $urandom_range(0, 1) ? C_MAX : C_MIN;
        end
        SEG_SHORT: begin
          bx = coord_t'(int'(ax) + int'($urandom_range(0, 16)) - 8);
          by = coord_t'(int'(ay) + int'($urandom_range(0, 16)) - 8);
        end
        SEG_AXIS: begin
          if ($urandom_range(0, 1)) by = ay;
          else bx = ax;
        end
        default: ;
      endcase
      set_segment(ax, ay, bx, by);

      send_idle = (phase % 3 != 1);
      recv_idle = (phase % 4 != 2);
      if (phase == 2) begin
        // sender runs flat out into a stalled output
        send_idle = 1'b0;
        hold_req  = 1'b1;
      end

      repeat (PHASE_ITEMS) begin
        qshape = query_shape_e'($urandom_range(0, 3));
        case (qshape)
          Q_NEAR_START: begin
            qx = coord_t'(int'(seg_ax) + int'($urandom_range(0, 1023)) - 512);
            qy = coord_t'(int'(seg_ay) + int'($urandom_range(0, 1023)) - 512);
          end
          Q_ALONG: begin
            k  = int'($urandom_range(0, 24)) - 4;
            qx = near_line(seg_ax, seg_bx, k);
            qy = near_line(seg_ay, seg_by, k);
          end
          Q_CORNER: begin
            qx = pick_corner();
            qy = pick_corner();
          end
          default: begin
            qx = coord_t'($urandom);
            qy = coord_t'($urandom);
          end
        endcase
        send_point(qx, qy, 1'b0, '0);
      end
    end

    wait_drained();
    repeat (psd_pkg::PIPE_DEPTH + 8) @(posedge clk_i);
    if (expected_dist.size() != 0) begin
      $display("ERROR: %0d expected dist words never arrived", expected_dist.size());
      n_errors++;
    end

    $display("Covered %0d query words on %0d segments (reset, degenerate, corner, short, axis)",
             n_sent, n_segments);
    $display("with %0d config writes, random stalls both ways and a %0d-cycle output hold",
             n_cfg_writes, HOLD_CYCLES);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
